// File: hw/rtl/rds_pkg.sv
// shared types, codes and the profile table of the retry deadline sequencer
package rds_pkg;

  localparam int unsigned RDS_PROFILES = 12;
  localparam int unsigned TAB_DEPTH    = 16;
  localparam logic [63:0] NS_PER_MS    = 64'd1000000;

  // item opcodes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_OUTCOME = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ISSUE   = 2'd0;
  localparam logic [1:0] KIND_FINAL   = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  // status codes
  localparam logic [2:0] ST_COMPLETED   = 3'd0;
  localparam logic [2:0] ST_TIMEOUT     = 3'd1;
  localparam logic [2:0] ST_FAILED      = 3'd2;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [2:0] ST_INVALID     = 3'd4;

  typedef struct packed {
    logic        op;
    logic [3:0]  profile;
    logic [63:0] now_ns;
    logic [2:0]  attempt_status;
    logic [31:0] dev_result;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] grant_ns;
    logic [2:0]  status;
    logic [6:0]  attempts;
    logic [63:0] since_start_ns;
    logic [31:0] result_code;
    logic [3:0]  profile_out;
  } out_item_t;

  typedef struct packed {
    logic        busy;
    logic [3:0]  active_profile;
    logic [63:0] start_time;
    logic [63:0] due_ns;
    logic [6:0]  attempts_done;
  } state_t;

  typedef struct packed {
    logic [6:0]  max_att;
    logic [63:0] per_ns;
    logic [63:0] total_ns;
  } prof_t;

  function automatic prof_t prof_lookup(input logic [3:0] idx);
    prof_t p;
    p = '{max_att: 7'd0, per_ns: 64'd0, total_ns: 64'd0};
    case (idx)
      4'd0:  p = '{7'd8,   64'd100 * NS_PER_MS, 64'd800 * NS_PER_MS};
      4'd1:  p = '{7'd8,   64'd100 * NS_PER_MS, 64'd800 * NS_PER_MS};
      4'd2:  p = '{7'd1,   NS_PER_MS,           NS_PER_MS};
      4'd3:  p = '{7'd8,   64'd10 * NS_PER_MS,  64'd80 * NS_PER_MS};
      4'd4:  p = '{7'd1,   NS_PER_MS,           NS_PER_MS};
      4'd5:  p = '{7'd8,   NS_PER_MS,           64'd8 * NS_PER_MS};
      4'd6:  p = '{7'd1,   64'd1,               64'd1};
      4'd7:  p = '{7'd1,   64'd1,               64'd1};
      4'd8:  p = '{7'd50,  64'd5 * NS_PER_MS,   64'd250 * NS_PER_MS};
      4'd9:  p = '{7'd100, 64'd10 * NS_PER_MS,  64'd1000 * NS_PER_MS};
      4'd10: p = '{7'd8,   64'd0,               64'd1000 * NS_PER_MS};
      4'd11: p = '{7'd64,  64'd0,               64'd0};
      default: p = '{max_att: 7'd0, per_ns: 64'd0, total_ns: 64'd0};
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/rds_step.sv
// evaluation of one item against the sequencer state
module rds_step
  import rds_pkg::*;
#(
  parameter int unsigned PROFILES = RDS_PROFILES
) (
  input  in_item_t  item,
  input  state_t    cur,
  output out_item_t res,
  output state_t    nxt
);

  localparam logic [4:0] PROF_LIMIT = 5'(PROFILES);
  localparam logic [3:0] PROF_MARK  = 4'(PROFILES);

  prof_t       new_ent;
  prof_t       act_ent;
  logic [64:0] dl_sum;
  logic [63:0] dl_new;
  logic [63:0] start_rem;
  logic        start_rem_zero;
  logic [64:0] dl_diff;
  logic        out_rem_zero;
  logic [63:0] elapsed;
  logic [63:0] per_sel;
  logic [63:0] rem_sel;
  logic [63:0] grant;
  logic [2:0]  st_clamp;
  logic        bad_prof;

  assign new_ent = prof_lookup(item.profile);
  assign act_ent = prof_lookup(cur.active_profile);

  // deadline at start, saturating; remaining time follows without a second subtract
  assign dl_sum         = {1'b0, item.now_ns} + {1'b0, new_ent.total_ns};
  assign dl_new         = dl_sum[64] ? '1 : dl_sum[63:0];
  assign start_rem      = dl_sum[64] ? ~item.now_ns : new_ent.total_ns;
  assign start_rem_zero = dl_sum[64] ? (&item.now_ns) : (new_ent.total_ns == 64'd0);

  // time left on an outcome
  assign dl_diff      = {1'b0, cur.due_ns} - {1'b0, item.now_ns};
  assign out_rem_zero = dl_diff[64] | (dl_diff[63:0] == 64'd0);
  assign elapsed      = item.now_ns - cur.start_time;

  // shared min of per-attempt timeout and remaining time
  assign per_sel = (item.op == OP_OUTCOME) ? act_ent.per_ns : new_ent.per_ns;
  assign rem_sel = (item.op == OP_OUTCOME) ? dl_diff[63:0] : start_rem;
  assign grant   = (per_sel < rem_sel) ? per_sel : rem_sel;

  assign st_clamp = (item.attempt_status inside {[3'd5:3'd7]}) ? ST_INVALID
                                                               : item.attempt_status;
  assign bad_prof = ({1'b0, item.profile} >= PROF_LIMIT) || (new_ent.max_att == 7'd0) ||
                    (new_ent.per_ns == 64'd0);

  always_comb begin
    res = '0;
    nxt = cur;
    res.kind = KIND_IGNORED;
    case (item.op)
      OP_START: begin
        if (cur.busy) begin
          res.kind = KIND_IGNORED;
        end else if (bad_prof) begin
          res.kind        = KIND_FINAL;
          res.status      = ST_INVALID;
          res.profile_out = PROF_MARK;
        end else begin
          nxt.start_time     = item.now_ns;
          nxt.due_ns         = dl_new;
          nxt.active_profile = item.profile;
          res.profile_out    = item.profile;
          if (start_rem_zero) begin
            nxt.attempts_done = 7'd0;
            res.kind          = KIND_FINAL;
            res.status        = ST_TIMEOUT;
          end else begin
            nxt.busy          = 1'b1;
            nxt.attempts_done = 7'd1;
            res.kind          = KIND_ISSUE;
            res.grant_ns      = grant;
            res.attempts      = 7'd1;
          end
        end
      end
      OP_OUTCOME: begin
        if (!cur.busy) begin
          res.kind = KIND_IGNORED;
        end else begin
          res.since_start_ns = elapsed;
          res.profile_out    = cur.active_profile;
          if (st_clamp != ST_TIMEOUT) begin
            nxt.busy        = 1'b0;
            res.kind        = KIND_FINAL;
            res.status      = st_clamp;
            res.attempts    = cur.attempts_done;
            res.result_code = item.dev_result;
          end else if (out_rem_zero || (cur.attempts_done >= act_ent.max_att)) begin
            nxt.busy        = 1'b0;
            res.kind        = KIND_FINAL;
            res.status      = ST_TIMEOUT;
            res.attempts    = cur.attempts_done;
            res.result_code = item.dev_result;
          end else begin
            nxt.attempts_done = cur.attempts_done + 7'd1;
            res.kind          = KIND_ISSUE;
            res.grant_ns      = grant;
            res.attempts      = cur.attempts_done + 7'd1;
          end
        end
      end
      default: begin
        res.kind = KIND_IGNORED;
      end
    endcase
  end

endmodule

// File: hw/rtl/retry_deadline_sequencer_unit.sv
// top level of the bounded retry sequencer with deadline timeout
//
// Takes an item per cycle unless stalled; exactly one result per item, in order.
// A start item looks up its profile (attempt limit, per-attempt timeout, total
// timeout), records the start time and a saturating deadline, and either
// issues the first attempt or finishes at once (invalid profile, no time
// left). An outcome item finishes the operation with its status, finishes it
// with a timeout when the deadline has passed or the attempts are used up, or
// issues the next attempt with min(per-attempt timeout, time remaining).
// All times come from now_ns of the item itself. Throughput is one transfer
// per cycle on each side while the output is not stalled. Each item passes
// through the input register and then the result register. The state update
// and the result are both made combinationally between those two registers,
// so the next item always sees the state the previous one left.
module retry_deadline_sequencer_unit
  import rds_pkg::*;
#(
  parameter int unsigned PROFILES = RDS_PROFILES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // input register
  logic      in_vld_r;
  logic      in_vld_nxt;
  in_item_t  item_r;

  // result register
  logic      out_vld_r;
  logic      out_vld_nxt;
  out_item_t res_r;

  // operation state
  state_t    st_r;
  state_t    st_nxt;
  out_item_t step_res;

  logic      advance;
  logic      in_xfer;

  // the held item moves on whenever the result slot is free or being emptied
  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;
  assign in_xfer  = in_valid & ~in_stall;

  assign in_vld_nxt  = in_xfer | (in_vld_r & ~advance);
  assign out_vld_nxt = advance | (out_vld_r & out_stall);

  rds_step #(
    .PROFILES(PROFILES)
  ) u_step (
    .item (item_r),
    .cur  (st_r),
    .res  (step_res),
    .nxt  (st_nxt)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = res_r;

endmodule

// File: hw/rtl/rds_checker.sv
// port-level checks of the retry deadline sequencer and their binding
module rds_checker
  import rds_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an issued attempt is counted, granted time, and carries no status or code
  a_issue_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_ISSUE |->
      out_data.attempts != 7'd0 && out_data.grant_ns != 64'd0 &&
      out_data.status == ST_COMPLETED && out_data.result_code == 32'd0)
    else $error("malformed attempt issue");

  // an ignored item reports zero grant, attempts, elapsed time and profile
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_IGNORED |->
      out_data.grant_ns == 64'd0 && out_data.attempts == 7'd0 &&
      out_data.since_start_ns == 64'd0 && out_data.profile_out == 4'd0)
    else $error("ignored item carries data");

  // a final result grants no time and no result kind is out of range
  a_final_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind != 2'd3 &&
      (out_data.kind != KIND_FINAL || out_data.grant_ns == 64'd0))
    else $error("bad final result");

endmodule

bind retry_deadline_sequencer_unit rds_checker u_rds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/retry_deadline_sequencer_unit_tb.sv
// testbench for the retry deadline sequencer: directed and random transfers against a predictor
`timescale 1ns / 1ps
module retry_deadline_sequencer_unit_tb;
  import rds_pkg::*;

  localparam int unsigned PROFILE_COUNT = RDS_PROFILES;
  localparam logic [63:0] MS = 64'd1000000;
  localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned ITEM_TARGET = 1100;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  // idling controls, flipped per phase
  bit gaps_on = 1'b0;
  bit stall_on = 1'b0;
  int stall_left = 0;

  int unsigned sent_items = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // predicted sequencer state
  logic seq_busy = 1'b0;
  logic [3:0] seq_profile = '0;
  logic [63:0] seq_start_ns = '0;
  logic [63:0] seq_due_ns = '0;
  logic [6:0] seq_attempts = '0;

  // results waiting for their transfer, oldest first
  out_item_t expected_results[$];

  retry_deadline_sequencer_unit #(
    .PROFILES(PROFILE_COUNT)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // attempt limit, per-attempt timeout, total timeout; entries above eleven stay zero
  function automatic prof_t retry_profile(input logic [3:0] idx);
    prof_t p;
    p = '0;
    case (idx)
      4'd0, 4'd1: p = '{7'd8, 64'd100 * MS, 64'd800 * MS};
      4'd2, 4'd4: p = '{7'd1, MS, MS};
      4'd3: p = '{7'd8, 64'd10 * MS, 64'd80 * MS};
      4'd5: p = '{7'd8, MS, 64'd8 * MS};
      4'd6, 4'd7: p = '{7'd1, 64'd1, 64'd1};
      4'd8: p = '{7'd50, 64'd5 * MS, 64'd250 * MS};
      4'd9: p = '{7'd100, 64'd10 * MS, 64'd1000 * MS};
      4'd10: p = '{7'd8, 64'd0, 64'd1000 * MS};
      4'd11: p = '{7'd64, 64'd0, 64'd0};
      default: p = '0;
    endcase
    return p;
  endfunction

  // time until the deadline, zero once it has passed
  function automatic logic [63:0] time_left(input logic [63:0] now);
    return (now >= seq_due_ns) ? 64'd0 : seq_due_ns - now;
  endfunction

  // works out the result of one accepted item and advances the predicted state
  task automatic predict_result(input in_item_t it);
    out_item_t r;
    prof_t p;
    logic [63:0] rem;
    logic [2:0] st;
    r = '0;
    if (it.op == OP_START) begin
      p = retry_profile(it.profile);
      if (seq_busy) begin
        // start while an operation runs is dropped, state kept
        r.kind = KIND_IGNORED;
      end else if (it.profile >= PROFILE_COUNT || p.max_att == 0 || p.per_ns == 0) begin
        r.kind = KIND_FINAL;
        r.status = ST_INVALID;
        r.profile_out = PROFILE_COUNT[3:0];
      end else begin
        seq_start_ns = it.now_ns;
        // deadline saturates at all ones
        seq_due_ns = (~it.now_ns < p.total_ns) ? T_MAX : it.now_ns + p.total_ns;
        seq_profile = it.profile;
        rem = time_left(it.now_ns);
        r.profile_out = it.profile;
        if (rem == 0) begin
          // no time left at all, finish with a timeout before any attempt
          seq_attempts = '0;
          r.kind = KIND_FINAL;
          r.status = ST_TIMEOUT;
        end else begin
          seq_busy = 1'b1;
          seq_attempts = 7'd1;
          r.kind = KIND_ISSUE;
          r.grant_ns = (p.per_ns < rem) ? p.per_ns : rem;
          r.attempts = 7'd1;
        end
      end
    end else if (!seq_busy) begin
      r.kind = KIND_IGNORED;
    end else begin
      p = retry_profile(seq_profile);
      // status codes past invalid fold into invalid
      st = (it.attempt_status > ST_INVALID) ? ST_INVALID : it.attempt_status;
      r.since_start_ns = it.now_ns - seq_start_ns;
      r.profile_out = seq_profile;
      rem = time_left(it.now_ns);
      if (st != ST_TIMEOUT || rem == 0 || seq_attempts >= p.max_att) begin
        seq_busy = 1'b0;
        r.kind = KIND_FINAL;
        r.status = st;
        r.attempts = seq_attempts;
        r.result_code = it.dev_result;
      end else begin
        seq_attempts = seq_attempts + 7'd1;
        r.kind = KIND_ISSUE;
        r.grant_ns = (p.per_ns < rem) ? p.per_ns : rem;
        r.attempts = seq_attempts;
      end
    end
    expected_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("grant_ns", want.grant_ns, got.grant_ns);
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("attempts", 64'(want.attempts), 64'(got.attempts));
      compare_field("since_start_ns", want.since_start_ns, got.since_start_ns);
      compare_field("result_code", 64'(want.result_code), 64'(got.result_code));
      compare_field("profile_out", 64'(want.profile_out), 64'(got.profile_out));
    end
  endtask

  // result monitor and run limit; values read here are those before the edge
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      check_result(out_data);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results pending", $time,
               expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // idling on both sides
  // ---------------------------------------------------------------------------

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stall: a run of stalled cycles, then the stall drops before the next run is picked
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else begin
      stall_left = pick_gap(stall_on);
    end
    out_stall <= (stall_left != 0);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_item(input logic op, input logic [3:0] prof,
                                         input logic [63:0] now, input logic [2:0] st,
                                         input logic [31:0] nat);
    in_item_t it;
    it.op = op;
    it.profile = prof;
    it.now_ns = now;
    it.attempt_status = st;
    it.dev_result = nat;
    return it;
  endfunction

  // one transfer on the input side; valid stays high across back-to-back items
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap(gaps_on);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_result(it);
    sent_items++;
  endtask

  task automatic test_ignored_and_invalid();
    // outcome with nothing running
    send_item(make_item(OP_OUTCOME, 4'd0, 64'd1000, ST_COMPLETED, 32'h1234_5678));
    // index out of range, top index, zero per-attempt timeouts
    send_item(make_item(OP_START, 4'd12, 64'd0, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_START, 4'd15, T_MAX, 3'd7, 32'hFFFF_FFFF));
    send_item(make_item(OP_START, 4'd10, 64'd77, ST_TIMEOUT, 32'd0));
    send_item(make_item(OP_START, 4'd11, 64'd5, ST_FAILED, 32'd9));
  endtask

  task automatic test_single_attempt();
    // issue, start while busy, then completion
    send_item(make_item(OP_START, 4'd0, 64'd0, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_START, 4'd1, 64'd10, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_OUTCOME, 4'd0, 64'd50 * MS, ST_COMPLETED, 32'h0000_00AA));
    // one-nanosecond budget: deadline already reached on the timeout
    send_item(make_item(OP_START, 4'd6, 64'd5, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_OUTCOME, 4'd3, 64'd6, ST_TIMEOUT, 32'd1));
    // single attempt used up while time remains
    send_item(make_item(OP_START, 4'd2, 64'd100, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_OUTCOME, 4'd2, 64'd100, ST_TIMEOUT, 32'h8000_0001));
  endtask

  task automatic test_retry_chain();
    // timeout with attempts left issues a retry, then a status past invalid
    send_item(make_item(OP_START, 4'd3, 64'd0, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_OUTCOME, 4'd0, 64'd5 * MS, ST_TIMEOUT, 32'd3));
    send_item(make_item(OP_OUTCOME, 4'd0, 64'd7 * MS, 3'd7, 32'd4));
    send_item(make_item(OP_START, 4'd9, 64'd123456, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_OUTCOME, 4'd9, 64'd223456, ST_UNSUPPORTED, 32'd0));
    send_item(make_item(OP_START, 4'd4, 64'd42, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_OUTCOME, 4'd4, 64'd43, ST_INVALID, 32'h5A5A_5A5A));
    send_item(make_item(OP_START, 4'd7, 64'd0, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_OUTCOME, 4'd7, 64'd0, 3'd5, 32'd6));
  endtask

  task automatic test_time_extremes();
    // start at the very top of time: saturated deadline, nothing left
    send_item(make_item(OP_START, 4'd8, T_MAX, ST_COMPLETED, 32'd0));
    // deadline saturates, then time wraps past zero before the outcome
    send_item(make_item(OP_START, 4'd5, T_MAX - 64'd3 * MS, ST_COMPLETED, 32'd0));
    send_item(make_item(OP_OUTCOME, 4'd5, 64'd5, ST_FAILED, 32'hFFFF_FFFF));
    send_item(make_item(OP_OUTCOME, 4'd5, 64'd6, 3'd6, 32'd0));
  endtask

  function automatic logic [63:0] random_start_time();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return T_MAX - 64'($urandom_range(0, 1000000000));
    if (r == 1) return 64'($urandom);
    return {$urandom, $urandom};
  endfunction

  // small steps keep long retry chains going, big ones hit the deadline or wrap
  function automatic logic [63:0] random_step(input bit small_only);
    int r;
    r = small_only ? 0 : $urandom_range(0, 9);
    if (r < 5) return 64'($urandom_range(0, 2000000));
    if (r < 9) return 64'($urandom_range(0, 300000000));
    return {$urandom, $urandom};
  endfunction

  // one start followed by outcomes until the operation ends
  task automatic run_operation();
    logic [3:0] prof;
    logic [63:0] now;
    logic [2:0] st;
    bit retry_only;
    int steps;
    prof = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                       : 4'($urandom_range(0, 9));
    now = random_start_time();
    send_item(make_item(OP_START, prof, now, 3'($urandom), $urandom));
    // some operations only ever time out, to run the attempt count to its limit
    retry_only = ($urandom_range(0, 3) == 0);
    steps = 0;
    while (seq_busy && steps < 120) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(make_item(OP_START, 4'($urandom), {$urandom, $urandom}, 3'($urandom),
                            $urandom));
      end
      now = now + random_step(retry_only);
      if (retry_only || $urandom_range(0, 5) != 0) begin
        st = ST_TIMEOUT;
      end else begin
        st = 3'($urandom);
      end
      send_item(make_item(OP_OUTCOME, 4'($urandom), now, st, $urandom));
      steps++;
    end
  endtask

  task automatic test_random_traffic();
    int unsigned next_switch;
    int n;
    next_switch = 0;
    while (sent_items < ITEM_TARGET) begin
      // change the idling pattern every hundred or so transfers
      if (sent_items >= next_switch) begin
        gaps_on = $urandom_range(0, 2) != 0;
        stall_on = $urandom_range(0, 2) != 0;
        next_switch = sent_items + 100;
      end
      if ($urandom_range(0, 6) == 0) begin
        // noise: any field, any value
        n = $urandom_range(1, 5);
        repeat (n) begin
          send_item(make_item(1'($urandom), 4'($urandom), {$urandom, $urandom},
                              3'($urandom), $urandom));
        end
      end else begin
        run_operation();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part back to back, then with idling on both sides
    test_ignored_and_invalid();
    test_single_attempt();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    test_retry_chain();
    test_time_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: retry_deadline_sequencer_unit.f
hw/rtl/rds_pkg.sv
hw/rtl/rds_step.sv
hw/rtl/retry_deadline_sequencer_unit.sv
hw/rtl/rds_checker.sv
dv/retry_deadline_sequencer_unit_tb.sv
